// File: src/amd3_pkg.sv
// Shared constants for the 3x3 alpha mask dilation block.
`timescale 1ns / 1ps

package amd3_pkg;

   // Register file layout
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam int WIDTH_REG_W = 11;
   localparam int HEIGHT_REG_W = 16;
   localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET = 11'd1024;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd1;

   // Row counter saturates here
   localparam int ROW_W = 17;
   localparam logic [ROW_W-1:0] ROW_CAP = 17'h1FFFF;

   // Stream payload widths
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 8;

   localparam int DEFAULT_MAX_WIDTH = 1024;

endpackage

// File: src/alpha_mask_dilate_3x3.sv
// Top level: streaming 3x3 dilation of the alpha-nonzero mask of a raster image.
`timescale 1ns / 1ps

// Pixels come in raster order, one alpha byte per transaction (tuser = 0), and each
// result transaction says whether the output pixel is opaque (0xFF000000) or zero:
// opaque when any pixel of its 3x3 neighborhood has nonzero alpha, with pixels
// outside image_width x image_height counted as transparent. The result for a pixel
// leaves with the transaction that carries the pixel image_width + 1 positions later,
// so after the last pixel send image_width + 1 flush transactions (tuser = 1) to
// drain the image; the final result has tlast set, after which the next transaction
// starts a new image. Flush transactions inside the image are dropped. The block
// takes one transaction per clock unless the result side stalls: the position
// counters settle in the accepting cycle, the two line stores are read at that
// edge, and the window and result are formed in the next stage, with a result
// register toward the output side. After reset the line stores are swept to
// zero, one column per clock, so req_tready stays low until the sweep is done;
// configuration writes are taken during that sweep. Write image_width
// (index 0) and image_height (index 1) only while no results are pending.
module alpha_mask_dilate_3x3 #(
   parameter int MAX_WIDTH = amd3_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   // pixel transactions
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [amd3_pkg::REQ_DATA_W-1:0]   req_tdata,   // [7:0] alpha
   input  logic [0:0]                        req_tuser,   // [0] req_type: 1 = flush
   // result transactions
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [amd3_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // [0] opaque, [7:1] zero
   output logic                              rsp_tlast,   // last_pixel
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [amd3_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [amd3_pkg::CSR_DATA_W-1:0]   csr_data
);
   import amd3_pkg::*;

   localparam int WW = $clog2(MAX_WIDTH + 1);      // holds 1..MAX_WIDTH
   localparam int CIW = $clog2(MAX_WIDTH);         // column index
   localparam int CW = (WW > WIDTH_REG_W) ? WW : WIDTH_REG_W;
   localparam int PW = WW + HEIGHT_REG_W;          // pixels per frame

   // ---------------------------------------------------------------- config
   logic [WIDTH_REG_W-1:0]  image_width_ff, image_width_in;
   logic [HEIGHT_REG_W-1:0] image_height_ff, image_height_in;

   assign csr_ready = 1'b1;

   always_comb begin
      image_width_in = image_width_ff;
      image_height_in = image_height_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  image_width_in = csr_data[WIDTH_REG_W-1:0];
            CSR_IMAGE_HEIGHT: image_height_in = csr_data[HEIGHT_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective size: zero acts as one, width clamps to the line store
   logic [CW-1:0]           width_wide;
   logic [WW-1:0]           w_eff;
   logic [HEIGHT_REG_W-1:0] h_eff;
   logic [PW-1:0]           frame_size;

   always_comb begin
      width_wide = CW'(image_width_ff);
      if (width_wide == '0) begin
         w_eff = WW'(1);
      end else if (width_wide > CW'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = width_wide[WW-1:0];
      end
      h_eff = (image_height_ff == '0) ? HEIGHT_REG_W'(1) : image_height_ff;
      frame_size = PW'(w_eff) * PW'(h_eff);
   end

   function automatic logic [ROW_W-1:0] row_inc(input logic [ROW_W-1:0] r);
      return (r < ROW_CAP) ? r + ROW_W'(1) : r;
   endfunction

   // ---------------------------------------------------------------- clear sweep
   logic           clr_busy_ff, clr_busy_in;
   logic [CIW-1:0] clr_cnt_ff, clr_cnt_in;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_cnt_in = clr_cnt_ff;
      if (clr_busy_ff) begin
         clr_cnt_in = clr_cnt_ff + CIW'(1);
         if (clr_cnt_ff == CIW'(MAX_WIDTH - 1)) begin
            clr_busy_in = 1'b0;
            clr_cnt_in = '0;
         end
      end
   end

   // ---------------------------------------------------------------- stage 0: position
   logic [CIW-1:0]   col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [PW-1:0]    cnt_ff, cnt_in;

   logic             acc, is_flush, wrap0, in_image, drop, end_row;
   logic [CIW-1:0]   c0, c1;
   logic [ROW_W-1:0] r0, r1;
   logic [WW-1:0]    ci_p1;
   logic [PW-1:0]    cnt_p1;
   logic             cur_new, top_en_new, mid_en_new, emit_new, last_new;

   // stage 1 control
   logic s1_valid_ff, s1_valid_in, s1_go, out_free;
   logic s1_emit_ff;

   assign out_free = !rsp_tvalid || rsp_tready;
   assign s1_go = s1_valid_ff && (!s1_emit_ff || out_free);
   assign req_tready = !clr_busy_ff && (!s1_valid_ff || s1_go);
   assign acc = req_tvalid && req_tready;
   assign is_flush = req_tuser[0];

   always_comb begin
      // a width lowered mid-row closes the row before this item
      wrap0 = WW'(col_ff) >= w_eff;
      c0 = wrap0 ? '0 : col_ff;
      r0 = wrap0 ? row_inc(row_ff) : row_ff;
      in_image = r0 < ROW_W'(h_eff);
      drop = is_flush && in_image;

      cur_new = in_image && (req_tdata != '0);
      top_en_new = r0 >= ROW_W'(2);
      mid_en_new = r0 != '0;
      emit_new = (r0 >= ROW_W'(2)) || ((r0 == ROW_W'(1)) && (c0 != '0));

      ci_p1 = WW'(c0) + WW'(1);
      end_row = ci_p1 >= w_eff;
      c1 = end_row ? '0 : ci_p1[CIW-1:0];
      r1 = end_row ? row_inc(r0) : r0;

      cnt_p1 = cnt_ff + PW'(1);
      last_new = emit_new && (cnt_p1 >= frame_size);

      col_in = col_ff;
      row_in = row_ff;
      cnt_in = cnt_ff;
      if (acc) begin
         if (drop) begin
            col_in = c0;
            row_in = r0;
         end else if (last_new) begin
            col_in = '0;
            row_in = '0;
            cnt_in = '0;
         end else begin
            col_in = c1;
            row_in = r1;
            if (emit_new) begin
               cnt_in = cnt_p1;
            end
         end
      end
   end

   // ---------------------------------------------------------------- line stores
   logic older_mem [MAX_WIDTH];
   logic prev_mem [MAX_WIDTH];

   logic           older_q_ff, prev_q_ff;
   logic           byp_ff, byp_in, byp_older_ff, byp_prev_ff;
   logic           mem_we, mem_older_wd, mem_prev_wd;
   logic [CIW-1:0] mem_waddr;
   logic           load_s1;

   assign load_s1 = acc && !drop;

   // stage 1 payload
   logic [CIW-1:0] s1_ci_ff;
   logic           s1_cur_ff, s1_top_en_ff, s1_mid_en_ff, s1_last_ff;

   logic           older_rd, prev_rd, top_bit, mid_bit;
   logic [2:0]     col3;
   logic [8:0]     win_ff, win_in, win_next;
   logic           opaque_new;

   always_comb begin
      older_rd = byp_ff ? byp_older_ff : older_q_ff;
      prev_rd = byp_ff ? byp_prev_ff : prev_q_ff;
      top_bit = s1_top_en_ff && older_rd;
      mid_bit = s1_mid_en_ff && prev_rd;
      col3 = {s1_cur_ff, mid_bit, top_bit};
      if (s1_ci_ff == '0) begin
         // center was the last column of its row: no right neighbor
         opaque_new = win_ff[8:3] != '0;
         win_next = {col3, 6'b0};
      end else begin
         win_next = {col3, win_ff[8:3]};
         opaque_new = win_next != '0;
      end
      win_in = win_ff;
      if (s1_go) begin
         win_in = s1_last_ff ? '0 : win_next;
      end

      mem_we = clr_busy_ff || s1_go;
      mem_waddr = clr_busy_ff ? clr_cnt_ff : s1_ci_ff;
      mem_older_wd = clr_busy_ff ? 1'b0 : mid_bit;
      mem_prev_wd = clr_busy_ff ? 1'b0 : s1_cur_ff;

      // read and write of the same column at one edge (width of one)
      byp_in = s1_go && (s1_ci_ff == c0);

      s1_valid_in = s1_valid_ff;
      if (load_s1) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         older_mem[mem_waddr] <= mem_older_wd;
         prev_mem[mem_waddr] <= mem_prev_wd;
      end
      if (load_s1) begin
         older_q_ff <= older_mem[c0];
         prev_q_ff <= prev_mem[c0];
      end
   end

   always_ff @(posedge clock) begin
      if (load_s1) begin
         byp_ff <= byp_in;
         byp_older_ff <= mem_older_wd;
         byp_prev_ff <= mem_prev_wd;
         s1_ci_ff <= c0;
         s1_cur_ff <= cur_new;
         s1_top_en_ff <= top_en_new;
         s1_mid_en_ff <= mid_en_new;
         s1_emit_ff <= emit_new;
         s1_last_ff <= last_new;
      end
   end

   // ---------------------------------------------------------------- result register
   logic rsp_valid_ff, rsp_valid_in, rsp_opaque_ff, rsp_last_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_go && s1_emit_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_emit_ff) begin
         rsp_opaque_ff <= opaque_new;
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {{(RSP_DATA_W - 1){1'b0}}, rsp_opaque_ff};
   assign rsp_tlast = rsp_last_ff;

   // ---------------------------------------------------------------- control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff <= WIDTH_RESET;
         image_height_ff <= HEIGHT_RESET;
         clr_busy_ff <= 1'b1;
         clr_cnt_ff <= '0;
         col_ff <= '0;
         row_ff <= '0;
         cnt_ff <= '0;
         s1_valid_ff <= 1'b0;
         win_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         image_width_ff <= image_width_in;
         image_height_ff <= image_height_in;
         clr_busy_ff <= clr_busy_in;
         clr_cnt_ff <= clr_cnt_in;
         col_ff <= col_in;
         row_ff <= row_in;
         cnt_ff <= cnt_in;
         s1_valid_ff <= s1_valid_in;
         win_ff <= win_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   // no pixel may enter while the line stores are being swept
   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !req_tready)
      else $error("transaction accepted during line store sweep");

   // the frame-ending pixel rewinds the position counters
   a_frame_rewind: assert property (@(posedge clock) disable iff (reset)
      (acc && !drop && last_new) |=> (col_ff == '0 && row_ff == '0 && cnt_ff == '0))
      else $error("position not rewound after last pixel");

   // the window is empty when the next image starts
   a_window_cleared: assert property (@(posedge clock) disable iff (reset)
      (s1_go && s1_last_ff) |=> (win_ff == '0))
      else $error("window not cleared at end of image");

   // a frame-ending result shows up with tlast on the next cycle
   a_last_reaches_port: assert property (@(posedge clock) disable iff (reset)
      (s1_go && s1_emit_ff && s1_last_ff) |=> (rsp_tvalid && rsp_tlast))
      else $error("last pixel result not presented");
`endif

endmodule

// File: tb/tb.sv
// Testbench for alpha_mask_dilate_3x3: streamed pixels against a scoreboard with its own dilation model.
`timescale 1ns / 1ps

module tb;
   import amd3_pkg::*;

   localparam int MAX_W = DEFAULT_MAX_WIDTH;
   localparam int ITEM_TARGET = 1250;   // random pixel/flush transactions to send
   localparam int IDLE_PCT = 11;        // percent of cycles each side idles
   localparam int STALL_LIMIT = 5000;   // covers the reset sweep plus stalls, many times over
   localparam int REPORT_MAX = 10;

   // Scoreboard: tracks line stores, 3x3 window and raster position like the block
   // does, and queues the output pixel each accepted transaction should produce.
   class dilation_scoreboard;
      typedef struct packed {
         bit opaque;
         bit last;
      } out_pixel_type;

      bit prev_row[MAX_W];
      bit older_row[MAX_W];
      bit [8:0] window;          // left column in [2:0], middle [5:3], right [8:6]
      int unsigned column;
      int unsigned row;
      int unsigned out_count;
      logic [WIDTH_REG_W-1:0] width_reg;
      logic [HEIGHT_REG_W-1:0] height_reg;
      out_pixel_type expected_pixels[$];
      int unsigned images_done;
      int unsigned errors;

      function new();
         width_reg = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_IMAGE_WIDTH: width_reg = data[WIDTH_REG_W-1:0];
            CSR_IMAGE_HEIGHT: height_reg = data[HEIGHT_REG_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned pending();
         return expected_pixels.size();
      endfunction

      function void note_pixel(bit flush, logic [7:0] alpha);
         int unsigned w, h, ci;
         bit in_image, cur, top, mid, opaque, emit, last;
         bit [2:0] col;
         out_pixel_type px;
         w = (width_reg == 0) ? 1 : ((width_reg > MAX_W) ? MAX_W : width_reg);
         h = (height_reg == 0) ? 1 : height_reg;
         // a width lowered mid-row closes the row right here
         if (column >= w) begin
            column = 0;
            if (row < ROW_CAP) row++;
         end
         in_image = row < h;
         if (flush && in_image) return;   // flush inside the image is dropped
         ci = column;
         cur = in_image && (alpha != 0);  // pixels past the image act as flush
         top = (row >= 2) ? older_row[ci] : 1'b0;
         mid = (row >= 1) ? prev_row[ci] : 1'b0;
         older_row[ci] = mid;
         prev_row[ci] = cur;
         col = {cur, mid, top};
         emit = (row >= 2) || (row == 1 && ci >= 1);
         if (ci == 0) begin
            // center sits in the last column of its row: no right neighbor
            opaque = |window[8:3];
            window = {col, 6'b0};
         end else begin
            window = {col, window[8:3]};
            opaque = |window;
         end
         if (ci + 1 >= w) begin
            column = 0;
            if (row < ROW_CAP) row++;
         end else begin
            column = ci + 1;
         end
         if (!emit) return;
         last = (out_count + 1) >= w * h;
         px.opaque = opaque;
         px.last = last;
         expected_pixels.insert(expected_pixels.size(), px);
         if (last) begin
            column = 0;
            row = 0;
            out_count = 0;
            window = '0;
            images_done++;
         end else begin
            out_count++;
         end
      endfunction

      function void check_pixel(logic [RSP_DATA_W-1:0] data, logic tlast);
         out_pixel_type exp_px;
         if (expected_pixels.size() == 0) begin
            errors++;
            if (errors <= REPORT_MAX)
               $display("unexpected result transaction: tdata %h tlast %b", data, tlast);
            return;
         end
         exp_px = expected_pixels.pop_front();
         if (data !== {{(RSP_DATA_W-1){1'b0}}, exp_px.opaque} || tlast !== exp_px.last) begin
            errors++;
            if (errors <= REPORT_MAX)
               $display("result mismatch: expected opaque %b last %b, got tdata %h tlast %b",
                        exp_px.opaque, exp_px.last, data, tlast);
         end
      endfunction

      function void close_out();
         if (expected_pixels.size() != 0) begin
            errors++;
            if (errors <= REPORT_MAX)
               $display("%0d expected results never arrived", expected_pixels.size());
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [0:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   logic no_idle = 1'b0;          // set for a long stretch with both sides streaming
   int unsigned items_sent = 0;
   int unsigned stall_cycles = 0;
   dilation_scoreboard sb = new();

   alpha_mask_dilate_3x3 #(.MAX_WIDTH(MAX_W)) u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Receiver backpressure: random stalls except during the streaming stretch.
   always @(posedge clock) begin
      rsp_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
   end

   // Result monitor. Values read right after the edge are the pre-edge ones,
   // since every testbench drive is nonblocking.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_pixel(rsp_tdata, rsp_tlast);
   end

   // Watchdog: too many cycles in a row without any transaction on any channel.
   initial begin
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   function automatic bit gap_now();
      return !no_idle && ($urandom_range(99) < IDLE_PCT);
   endfunction

   function automatic logic [7:0] rand_alpha();
      // mostly transparent so the dilation has edges to grow
      return ($urandom_range(9) < 7) ? 8'h00 : 8'($urandom_range(1, 255));
   endfunction

   // One pixel or flush transaction; req_tvalid stays high afterward so the
   // next call can stream back to back. Anything that waits lowers it first.
   task automatic send_item(bit flush, logic [7:0] alpha);
      while (gap_now()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= flush;
      req_tdata <= alpha;
      do @(posedge clock); while (!req_tready);
      sb.note_pixel(flush, alpha);
      items_sent++;
   endtask

   // Hold the sender until every expected result is out, then let the
   // pipeline settle in case the last items made none.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic put_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
   endtask

   task automatic configure(bit set_w, logic [CSR_DATA_W-1:0] w_data,
                            bit set_h, logic [CSR_DATA_W-1:0] h_data);
      bit h_first;
      h_first = $urandom_range(1);
      wait_idle();
      if (set_h && h_first) put_reg(CSR_IMAGE_HEIGHT, h_data);
      if (set_w) put_reg(CSR_IMAGE_WIDTH, w_data);
      if (set_h && !h_first) put_reg(CSR_IMAGE_HEIGHT, h_data);
      csr_valid <= 1'b0;
   endtask

   // One image of w x h pixels with some dropped flushes mixed in, sometimes
   // cut short by shrinking width or height partway, then drained with flush
   // ticks or stray pixels until the last-flagged result is due.
   task automatic run_image(int unsigned w, int unsigned h);
      int unsigned start, pixels, cut;
      start = sb.images_done;
      pixels = 0;
      cut = (w * h > 1 && $urandom_range(7) == 0) ? $urandom_range(1, w * h - 1) : 0;
      while (sb.images_done == start && pixels < w * h) begin
         if (cut != 0 && pixels == cut) begin
            if (w > 1 && (h == 1 || $urandom_range(1)))
               configure(1'b1, 16'($urandom_range(1, w - 1)), 1'b0, '0);
            else if (h > 1)
               configure(1'b0, '0, 1'b1, 16'($urandom_range(1, h - 1)));
         end
         if ($urandom_range(19) == 0) begin
            send_item(1'b1, 8'($urandom));
         end else begin
            send_item(1'b0, rand_alpha());
            pixels++;
         end
      end
      while (sb.images_done == start)
         send_item($urandom_range(3) != 0, 8'($urandom));
   endtask

   initial begin : main
      int unsigned w_reg, h_reg, pick, i;
      logic [7:0] seed_alpha[9];

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // 3x3 image: alpha extremes, a dropped flush mid-image, and a drain
      // mixing flush ticks with pixels past the end (alpha ignored)
      seed_alpha = '{8'h00, 8'hFF, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80};
      configure(1'b1, 16'd3, 1'b1, 16'd3);
      for (i = 0; i < 9; i++) begin
         send_item(1'b0, seed_alpha[i]);
         if (i == 3) send_item(1'b1, 8'hA5);
      end
      send_item(1'b1, 8'h00);
      send_item(1'b0, 8'hFF);
      send_item(1'b1, 8'h00);
      send_item(1'b0, 8'h7F);

      // zero width and height both act as 1: single-pixel image
      configure(1'b1, 16'h0000, 1'b1, 16'h0000);
      send_item(1'b0, 8'h01);
      send_item(1'b1, 8'h00);
      send_item(1'b1, 8'h00);

      // all-ones writes: width clamps to MAX_W, height 65535; then width is
      // lowered mid-row, and height lowered below the outputs already sent
      configure(1'b1, 16'hFFFF, 1'b1, 16'hFFFF);
      send_item(1'b0, 8'hFF);
      send_item(1'b0, 8'h00);
      send_item(1'b0, 8'h00);
      configure(1'b1, 16'd2, 1'b0, '0);
      send_item(1'b0, 8'h00);
      send_item(1'b0, 8'h00);
      send_item(1'b0, 8'h00);
      send_item(1'b0, 8'h01);
      configure(1'b0, '0, 1'b1, 16'd1);
      send_item(1'b1, 8'h00);

      // random images, mostly narrow; upper data bits of the width write are
      // junk the register should drop
      items_sent = 0;
      while (items_sent < ITEM_TARGET) begin
         pick = $urandom_range(99);
         if (pick < 3) w_reg = 0;
         else if (pick < 70) w_reg = $urandom_range(1, 8);
         else if (pick < 95) w_reg = $urandom_range(9, 32);
         else w_reg = $urandom_range(33, 100);
         h_reg = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 6);
         no_idle <= (items_sent >= 400 && items_sent < 700);
         configure(1'b1, {5'($urandom), 11'(w_reg)}, 1'b1, 16'(h_reg));
         run_image((w_reg == 0) ? 1 : w_reg, (h_reg == 0) ? 1 : h_reg);
      end

      wait_idle();
      sb.close_out();
      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: files.f
src/amd3_pkg.sv
src/alpha_mask_dilate_3x3.sv
tb/tb.sv
